[src/bankers_deadlock_avoidance_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the deadlock avoidance unit
// Each macro checks a property on the rising clock edge, outside reset.
// ---------------------------------------------------------------------------
`ifndef BANKERS_DEADLOCK_AVOIDANCE_UNIT_DEFINES_SVH
`define BANKERS_DEADLOCK_AVOIDANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BDA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bda assertion failed");

// Next-cycle implication.
`define BDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bda assertion failed");

`else

`define BDA_ASSERT(lbl, ante, cons)
`define BDA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[src/bda_pkg.sv]
// ---------------------------------------------------------------------------
// bda_pkg
// Sizes, codes, command types and vector helpers of the deadlock avoidance
// unit.
// ---------------------------------------------------------------------------
package bda_pkg;

  localparam int PROCS      = 4;
  localparam int RES_TYPES  = 4;
  localparam int VEC_FIELDS = 4;
  localparam int DATA_W     = 8;
  localparam int PROC_W     = 4;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int FCOUNT_W   = 5;
  localparam int PIDX_W     = $clog2(PROCS);
  localparam int CNT_W      = $clog2(PROCS + 1);

  typedef logic [DATA_W-1:0]                  data_t;
  typedef logic [RES_TYPES-1:0][DATA_W-1:0]   vec_t;
  typedef logic [VEC_FIELDS-1:0][DATA_W-1:0]  field_vec_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_AVAIL = 2'd1,
    MODE_REQ   = 2'd2,
    MODE_CHECK = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXCEEDS   = 3'd1,
    ST_WAIT      = 3'd2,
    ST_UNSAFE    = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic walk_step;
    logic finish;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_walk;
    logic walk_done;
  } dp_stat_t;

  typedef struct packed {
    status_t               status;
    logic                  safe;
    logic [FCOUNT_W-1:0]   finished_count;
    field_vec_t            avail;
  } result_t;

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

  function automatic vec_t sat_add_vec(input vec_t a, input vec_t b);
    vec_t r;
    for (int t = 0; t < RES_TYPES; t++) begin
      r[t] = sat_add(a[t], b[t]);
    end
    return r;
  endfunction

  function automatic vec_t sub_vec(input vec_t a, input vec_t b);
    vec_t r;
    for (int t = 0; t < RES_TYPES; t++) begin
      r[t] = a[t] - b[t];
    end
    return r;
  endfunction

  // True when every type of small is at most the same type of big.
  function automatic logic fits(input vec_t small_v, input vec_t big_v);
    logic ok;
    ok = 1'b1;
    for (int t = 0; t < RES_TYPES; t++) begin
      if (small_v[t] > big_v[t]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[src/bda_if.sv]
// ---------------------------------------------------------------------------
// bda_in_if / bda_out_if
// Valid/ready channels for the item words and the result words.
// ---------------------------------------------------------------------------
interface bda_in_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::MODE_W-1:0]  mode;
  logic [bda_pkg::PROC_W-1:0]  process;
  logic [bda_pkg::DATA_W-1:0]  vec_a0;
  logic [bda_pkg::DATA_W-1:0]  vec_a1;
  logic [bda_pkg::DATA_W-1:0]  vec_a2;
  logic [bda_pkg::DATA_W-1:0]  vec_a3;
  logic [bda_pkg::DATA_W-1:0]  need_b0;
  logic [bda_pkg::DATA_W-1:0]  need_b1;
  logic [bda_pkg::DATA_W-1:0]  need_b2;
  logic [bda_pkg::DATA_W-1:0]  need_b3;

  modport source (
    output valid, mode, process, vec_a0, vec_a1, vec_a2, vec_a3,
           need_b0, need_b1, need_b2, need_b3,
    input  ready
  );
  modport sink (
    input  valid, mode, process, vec_a0, vec_a1, vec_a2, vec_a3,
           need_b0, need_b1, need_b2, need_b3,
    output ready
  );
endinterface

interface bda_out_if;
  logic                          valid;
  logic                          ready;
  logic [bda_pkg::STATUS_W-1:0]  status;
  logic                          safe;
  logic [bda_pkg::FCOUNT_W-1:0]  finished_count;
  logic [bda_pkg::DATA_W-1:0]    avail_out0;
  logic [bda_pkg::DATA_W-1:0]    avail_out1;
  logic [bda_pkg::DATA_W-1:0]    avail_out2;
  logic [bda_pkg::DATA_W-1:0]    avail_out3;

  modport source (
    output valid, status, safe, finished_count,
           avail_out0, avail_out1, avail_out2, avail_out3,
    input  ready
  );
  modport sink (
    input  valid, status, safe, finished_count,
           avail_out0, avail_out1, avail_out2, avail_out3,
    output ready
  );
endinterface

[src/bankers_deadlock_avoidance_unit.sv]
// ---------------------------------------------------------------------------
// bankers_deadlock_avoidance_unit
// Resource allocator with a safety check against deadlock.
// in_ch carries one item word: mode selects a row load, an available load,
// a resource request or a bare safety check. out_ch returns one result word
// per item: status, safe flag, finished count and the available vector.
// An item is taken on in_ch only while the sequencer is idle. A load, an
// available load or a refused request goes from the decode step straight to
// the result step, where its result word is loaded into the output register.
// A granted request or a check adds the safety walk, one table row per cycle,
// and a finish step. A pass that finds a process stops at it and a pass that
// finds none reads all PROCS rows, so the walk reads at most 13 rows with
// four processes. The walk runs over the single table read port.
// The result sits in an output register, so a stalled receiver holds only
// the finished word; the next item is accepted and runs meanwhile, and waits
// in its last cycle until that register is free.
// Reset clears the tables, the available vector and all control state.
// ---------------------------------------------------------------------------
module bankers_deadlock_avoidance_unit (
  input  logic        clk,
  input  logic        rst_n,
  bda_in_if.sink      in_ch,
  bda_out_if.source   out_ch
);

  bda_pkg::dp_cmd_t     cmd;
  bda_pkg::dp_stat_t    stat;
  bda_pkg::field_vec_t  in_vec;
  bda_pkg::field_vec_t  in_need;
  bda_pkg::result_t     res;

  assign in_vec  = {in_ch.vec_a3, in_ch.vec_a2, in_ch.vec_a1, in_ch.vec_a0};
  assign in_need = {in_ch.need_b3, in_ch.need_b2, in_ch.need_b1, in_ch.need_b0};

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_ch.mode),
    .in_process (in_ch.process),
    .in_vec     (in_vec),
    .in_need    (in_need),
    .res        (res)
  );

  assign out_ch.status         = res.status;
  assign out_ch.safe           = res.safe;
  assign out_ch.finished_count = res.finished_count;
  assign out_ch.avail_out0     = res.avail[0];
  assign out_ch.avail_out1     = res.avail[1];
  assign out_ch.avail_out2     = res.avail[2];
  assign out_ch.avail_out3     = res.avail[3];

endmodule

[src/bda_dp.sv]
// ---------------------------------------------------------------------------
// bda_dp
// Allocation and need tables, available and work vectors, the safety walk
// scanner, rollback copies and the result register.
// ---------------------------------------------------------------------------
`include "bankers_deadlock_avoidance_unit_defines.svh"

module bda_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bda_pkg::dp_cmd_t                      cmd,
  output bda_pkg::dp_stat_t                     stat,
  input  logic [bda_pkg::MODE_W-1:0]            in_mode,
  input  logic [bda_pkg::PROC_W-1:0]            in_process,
  input  bda_pkg::field_vec_t                   in_vec,
  input  bda_pkg::field_vec_t                   in_need,
  output bda_pkg::result_t                      res
);

  bda_pkg::mode_t                     mode_r;
  logic [bda_pkg::PROC_W-1:0]         proc_r;
  bda_pkg::vec_t                      vec_r;
  bda_pkg::vec_t                      nd_r;

  bda_pkg::vec_t                      alloc_r [bda_pkg::PROCS];
  bda_pkg::vec_t                      need_r  [bda_pkg::PROCS];
  bda_pkg::vec_t                      avail_r;
  bda_pkg::vec_t                      work_r;
  logic [bda_pkg::PROCS-1:0]          flags_r;
  logic [bda_pkg::PIDX_W-1:0]         walk_idx_r;
  logic [bda_pkg::CNT_W-1:0]          count_r;
  bda_pkg::status_t                   status_r;

  bda_pkg::vec_t                      save_alloc_r;
  bda_pkg::vec_t                      save_need_r;
  bda_pkg::vec_t                      save_avail_r;
  bda_pkg::result_t                   res_r;

  logic                               proc_ok;
  logic [bda_pkg::PIDX_W-1:0]         pidx;
  logic [bda_pkg::PIDX_W-1:0]         rd_idx;
  bda_pkg::vec_t                      row_alloc;
  bda_pkg::vec_t                      row_need;
  logic                               fit_need;
  logic                               fit_avail;
  logic                               req_grant;
  logic                               hit;
  logic                               last_find;
  logic                               last_row;
  logic                               safe_now;
  logic                               need_zero;
  bda_pkg::status_t                   status_exec;
  bda_pkg::field_vec_t                avail_field;

  assign proc_ok = {1'b0, proc_r} < (bda_pkg::PROC_W + 1)'(bda_pkg::PROCS);
  assign pidx    = proc_r[bda_pkg::PIDX_W-1:0];

  // One row read port: the walk scans by its own index, everything else
  // addresses the row of the item's process.
  assign rd_idx    = cmd.walk_step ? walk_idx_r : pidx;
  assign row_alloc = alloc_r[rd_idx];
  assign row_need  = need_r[rd_idx];

  assign fit_need  = bda_pkg::fits(vec_r, row_need);
  assign fit_avail = bda_pkg::fits(vec_r, avail_r);
  assign req_grant = (mode_r == bda_pkg::MODE_REQ) && proc_ok && fit_need && fit_avail;

  assign hit       = !flags_r[walk_idx_r] && bda_pkg::fits(row_need, work_r);
  assign last_find = count_r == bda_pkg::CNT_W'(bda_pkg::PROCS - 1);
  assign last_row  = walk_idx_r == bda_pkg::PIDX_W'(bda_pkg::PROCS - 1);
  assign safe_now  = count_r == bda_pkg::CNT_W'(bda_pkg::PROCS);
  assign need_zero = row_need == '0;

  assign stat.start_walk = (mode_r == bda_pkg::MODE_CHECK) || req_grant;
  assign stat.walk_done  = hit ? last_find : last_row;

  always_comb begin
    status_exec = bda_pkg::ST_OK;
    priority if ((mode_r == bda_pkg::MODE_LOAD || mode_r == bda_pkg::MODE_REQ) && !proc_ok) begin
      status_exec = bda_pkg::ST_BAD_INDEX;
    end else if (mode_r == bda_pkg::MODE_REQ && !fit_need) begin
      status_exec = bda_pkg::ST_EXCEEDS;
    end else if (mode_r == bda_pkg::MODE_REQ && !fit_avail) begin
      status_exec = bda_pkg::ST_WAIT;
    end else begin
      status_exec = bda_pkg::ST_OK;
    end
  end

  always_comb begin
    avail_field = '0;
    for (int t = 0; t < bda_pkg::RES_TYPES; t++) begin
      avail_field[t] = avail_r[t];
    end
  end

  // Tables and walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < bda_pkg::PROCS; p++) begin
        alloc_r[p] <= '0;
        need_r[p]  <= '0;
      end
      avail_r    <= '0;
      work_r     <= '0;
      flags_r    <= '0;
      walk_idx_r <= '0;
      count_r    <= '0;
      status_r   <= bda_pkg::ST_OK;
    end else begin
      if (cmd.accept) begin
        flags_r <= '0;
        count_r <= '0;
      end
      if (cmd.exec) begin
        status_r <= status_exec;
        unique case (mode_r)
          bda_pkg::MODE_LOAD: begin
            if (proc_ok) begin
              alloc_r[pidx] <= vec_r;
              need_r[pidx]  <= nd_r;
            end
          end
          bda_pkg::MODE_AVAIL: begin
            avail_r <= vec_r;
          end
          bda_pkg::MODE_CHECK: begin
            work_r     <= avail_r;
            walk_idx_r <= '0;
          end
          bda_pkg::MODE_REQ: begin
            // Tentative grant; the walk starts from the reduced available.
            if (req_grant) begin
              alloc_r[pidx] <= bda_pkg::sat_add_vec(row_alloc, vec_r);
              need_r[pidx]  <= bda_pkg::sub_vec(row_need, vec_r);
              avail_r       <= bda_pkg::sub_vec(avail_r, vec_r);
              work_r        <= bda_pkg::sub_vec(avail_r, vec_r);
              walk_idx_r    <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk_step) begin
        // A hit ends the pass; the next pass rescans from the first row.
        if (hit) begin
          flags_r[walk_idx_r] <= 1'b1;
          count_r             <= count_r + 1'b1;
          work_r              <= bda_pkg::sat_add_vec(work_r, row_alloc);
          walk_idx_r          <= '0;
        end else if (!last_row) begin
          walk_idx_r <= walk_idx_r + 1'b1;
        end
      end
      if (cmd.finish && mode_r == bda_pkg::MODE_REQ) begin
        if (safe_now) begin
          // A process whose need is met hands its allocation back.
          if (need_zero) begin
            avail_r       <= bda_pkg::sat_add_vec(avail_r, row_alloc);
            alloc_r[pidx] <= '0;
          end
        end else begin
          alloc_r[pidx] <= save_alloc_r;
          need_r[pidx]  <= save_need_r;
          avail_r       <= save_avail_r;
          status_r      <= bda_pkg::ST_UNSAFE;
        end
      end
    end
  end

  // Item word, rollback copies and result word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= bda_pkg::mode_t'(in_mode);
      proc_r <= in_process;
      for (int t = 0; t < bda_pkg::RES_TYPES; t++) begin
        vec_r[t] <= in_vec[t];
        nd_r[t]  <= in_need[t];
      end
    end
    if (cmd.exec) begin
      save_alloc_r <= row_alloc;
      save_need_r  <= row_need;
      save_avail_r <= avail_r;
    end
    if (cmd.load_out) begin
      res_r.status         <= status_r;
      res_r.safe           <= safe_now;
      res_r.finished_count <= bda_pkg::FCOUNT_W'(count_r);
      res_r.avail          <= avail_field;
    end
  end

  assign res = res_r;

  `BDA_ASSERT(a_flags_match_count, 1'b1, $countones(flags_r) == int'(count_r))
  `BDA_ASSERT(a_work_grows, cmd.walk_step && $past(cmd.walk_step),
              work_r[0] >= $past(work_r[0]))

endmodule

[src/bda_ctrl.sv]
// ---------------------------------------------------------------------------
// bda_ctrl
// Sequencer of the deadlock avoidance unit: takes a word, runs the decode,
// walk and finish steps, and owns the result valid flag.
// ---------------------------------------------------------------------------
`include "bankers_deadlock_avoidance_unit_defines.svh"

module bda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bda_pkg::dp_cmd_t   cmd,
  input  bda_pkg::dp_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_FIN,
    S_RESULT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  assign cmd.accept    = in_valid && in_ready;
  assign cmd.exec      = state_r == S_EXEC;
  assign cmd.walk_step = state_r == S_WALK;
  assign cmd.finish    = state_r == S_FIN;
  assign cmd.load_out  = (state_r == S_RESULT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new word may take the output register in the cycle the old one leaves.
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= stat.start_walk ? S_WALK : S_RESULT;
        end
        S_WALK: begin
          if (stat.walk_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          // The result word waits here until the output register is free.
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `BDA_ASSERT(a_result_from_result_state, $rose(out_valid_r), $past(state_r == S_RESULT))
  `BDA_ASSERT_NXT(a_accept_starts_exec, in_valid && in_ready, state_r == S_EXEC)
  `BDA_ASSERT_NXT(a_walk_end_finishes, state_r == S_WALK && stat.walk_done,
                  state_r == S_FIN)

endmodule

[tb/sv/bda_grant_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grant checker for the deadlock avoidance unit
// Watches both channels, keeps its own copy of the allocation, need and
// available tables, predicts the result word of every accepted item and
// compares each returned word with the oldest prediction.
// ----------------------------------------------------------------------------
module bda_grant_checker
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bda_in_if           in_ch,
  bda_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned words_pending
);

  vec_t        alloc_rows [PROCS];
  vec_t        need_rows  [PROCS];
  vec_t        avail_now;
  result_t     verdict_q [$];
  int unsigned errors;

  function automatic logic [DATA_W-1:0] clamp_sum(input logic [DATA_W-1:0] x,
                                                  input logic [DATA_W-1:0] y);
    int s;
    s = int'(x) + int'(y);
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic bit within_limit(input vec_t ask, input vec_t cap);
    bit ok;
    ok = 1'b1;
    for (int t = 0; t < RES_TYPES; t++) begin
      if (ask[t] > cap[t]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Each pass retires the lowest-numbered open process whose need fits.
  function automatic int unsigned count_retirable();
    vec_t             work;
    logic [PROCS-1:0] retired;
    int unsigned      n;
    bit               found;
    work    = avail_now;
    retired = '0;
    n       = 0;
    for (int k = 0; k < PROCS; k++) begin
      found = 1'b0;
      for (int i = 0; i < PROCS; i++) begin
        if (!found && !retired[i] && within_limit(need_rows[i], work)) begin
          found      = 1'b1;
          retired[i] = 1'b1;
          n++;
          for (int t = 0; t < RES_TYPES; t++) begin
            work[t] = clamp_sum(work[t], alloc_rows[i][t]);
          end
        end
      end
    end
    return n;
  endfunction

  function automatic result_t apply_item(input mode_t m, input logic [PROC_W-1:0] p,
                                         input field_vec_t fa, input field_vec_t fb);
    result_t     r;
    vec_t        ask, nd, keep_alloc, keep_need, keep_avail;
    int unsigned n;
    bit          row_clear;
    r        = '0;
    r.status = ST_OK;
    for (int t = 0; t < RES_TYPES; t++) begin
      ask[t] = fa[t];
      nd[t]  = fb[t];
    end
    case (m)
      MODE_LOAD: begin
        if (int'(p) >= PROCS) begin
          r.status = ST_BAD_INDEX;
        end else begin
          alloc_rows[p] = ask;
          need_rows[p]  = nd;
        end
      end
      MODE_AVAIL: begin
        avail_now = ask;
      end
      MODE_CHECK: begin
        n                = count_retirable();
        r.finished_count = FCOUNT_W'(n);
        r.safe           = (n == PROCS);
      end
      default: begin
        if (int'(p) >= PROCS) begin
          r.status = ST_BAD_INDEX;
        end else if (!within_limit(ask, need_rows[p])) begin
          r.status = ST_EXCEEDS;
        end else if (!within_limit(ask, avail_now)) begin
          r.status = ST_WAIT;
        end else begin
          keep_alloc = alloc_rows[p];
          keep_need  = need_rows[p];
          keep_avail = avail_now;
          for (int t = 0; t < RES_TYPES; t++) begin
            alloc_rows[p][t] = clamp_sum(alloc_rows[p][t], ask[t]);
            need_rows[p][t]  = need_rows[p][t] - ask[t];
            avail_now[t]     = avail_now[t] - ask[t];
          end
          n                = count_retirable();
          r.finished_count = FCOUNT_W'(n);
          r.safe           = (n == PROCS);
          if (r.safe) begin
            row_clear = (need_rows[p] == '0);
            // A process whose need is met hands its whole allocation back.
            if (row_clear) begin
              for (int t = 0; t < RES_TYPES; t++) begin
                avail_now[t] = clamp_sum(avail_now[t], alloc_rows[p][t]);
              end
              alloc_rows[p] = '0;
            end
          end else begin
            r.status      = ST_UNSAFE;
            alloc_rows[p] = keep_alloc;
            need_rows[p]  = keep_need;
            avail_now     = keep_avail;
          end
        end
      end
    endcase
    for (int t = 0; t < VEC_FIELDS; t++) begin
      if (t < RES_TYPES) begin
        r.avail[t] = avail_now[t];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
  end

  always @(posedge clk) begin : watch
    result_t    want;
    field_vec_t fa, fb;
    if (!rst_n) begin
      for (int i = 0; i < PROCS; i++) begin
        alloc_rows[i] = '0;
        need_rows[i]  = '0;
      end
      avail_now = '0;
      verdict_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          errors++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("safe", want.safe, out_ch.safe);
          check_field("finished_count", want.finished_count, out_ch.finished_count);
          check_field("avail_out0", want.avail[0], out_ch.avail_out0);
          check_field("avail_out1", want.avail[1], out_ch.avail_out1);
          check_field("avail_out2", want.avail[2], out_ch.avail_out2);
          check_field("avail_out3", want.avail[3], out_ch.avail_out3);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fa = {in_ch.vec_a3, in_ch.vec_a2, in_ch.vec_a1, in_ch.vec_a0};
        fb = {in_ch.need_b3, in_ch.need_b2, in_ch.need_b1, in_ch.need_b0};
        verdict_q.push_back(apply_item(mode_t'(in_ch.mode), in_ch.process, fa, fb));
      end
    end
    words_pending <= verdict_q.size();
    fail_count    <= errors;
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench top for the deadlock avoidance unit
// Drives directed and random item words in bursts, stalls the result side on
// its own pattern with one long hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import bda_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;

  bda_in_if  in_if ();
  bda_out_if out_if ();

  bankers_deadlock_avoidance_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  bda_grant_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic field_vec_t vec_of(input int x0, input int x1, input int x2,
                                        input int x3);
    field_vec_t v;
    v[0] = 8'(x0);
    v[1] = 8'(x1);
    v[2] = 8'(x2);
    v[3] = 8'(x3);
    return v;
  endfunction

  // At least a third of the counts are zero so that requests often fit their limits.
  function automatic field_vec_t rand_vec(input int hi);
    field_vec_t v;
    for (int t = 0; t < VEC_FIELDS; t++) begin
      v[t] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, hi));
    end
    return v;
  endfunction

  task automatic offer(input mode_t m, input logic [PROC_W-1:0] p,
                       input field_vec_t a, input field_vec_t b);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= m;
    in_if.process <= p;
    in_if.vec_a0  <= a[0];
    in_if.vec_a1  <= a[1];
    in_if.vec_a2  <= a[2];
    in_if.vec_a3  <= a[3];
    in_if.need_b0 <= b[0];
    in_if.need_b1 <= b[1];
    in_if.need_b2 <= b[2];
    in_if.need_b3 <= b[3];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  initial begin : stimulus
    int         hi;
    int         pick;
    field_vec_t none;
    field_vec_t full;
    none          = '0;
    full          = '1;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_LOAD;
    in_if.process <= '0;
    in_if.vec_a0  <= '0;
    in_if.vec_a1  <= '0;
    in_if.vec_a2  <= '0;
    in_if.vec_a3  <= '0;
    in_if.need_b0 <= '0;
    in_if.need_b1 <= '0;
    in_if.need_b2 <= '0;
    in_if.need_b3 <= '0;
    burst_left    = 0;
    words_sent    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tables are all zero after reset, so a bare check retires everyone.
    offer(MODE_CHECK, 4'd0, none, none);
    offer(MODE_LOAD, 4'd15, full, full);
    offer(MODE_REQ, PROC_W'(PROCS), vec_of(1, 0, 0, 0), none);
    offer(MODE_AVAIL, 4'd15, vec_of(1, 0, 0, 0), full);
    offer(MODE_LOAD, 4'd0, none, vec_of(2, 0, 0, 0));
    offer(MODE_LOAD, 4'd1, vec_of(2, 0, 0, 0), vec_of(1, 0, 0, 0));
    offer(MODE_LOAD, 4'd2, none, none);
    offer(MODE_LOAD, 4'd3, none, none);
    offer(MODE_CHECK, 4'd7, none, full);
    // Granting one unit to process 0 leaves nobody able to finish it off.
    offer(MODE_REQ, 4'd0, vec_of(1, 0, 0, 0), full);
    offer(MODE_REQ, 4'd0, vec_of(3, 0, 0, 0), none);
    offer(MODE_REQ, 4'd0, vec_of(2, 0, 0, 0), none);
    offer(MODE_REQ, 4'd2, none, none);
    // Process 1 reaches zero need and releases its allocation.
    offer(MODE_REQ, 4'd1, vec_of(1, 0, 0, 0), none);
    offer(MODE_LOAD, 4'd3, full, none);
    offer(MODE_AVAIL, 4'd0, vec_of(200, 200, 200, 200), none);
    offer(MODE_CHECK, 4'd9, full, full);
    offer(MODE_REQ, 4'd3, none, none);
    offer(MODE_LOAD, 4'd2, none, full);
    offer(MODE_REQ, 4'd2, full, none);
    offer(MODE_REQ, 4'd2, full, none);
    offer(MODE_CHECK, 4'd15, none, none);

    // Random part: load a table, set what is free, then a run of requests mixed with checks and random items.
    while (words_sent < ITEM_TARGET) begin
      hi = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(3, 15);
      for (int i = 0; i < PROCS; i++) begin
        offer(MODE_LOAD, PROC_W'(i), rand_vec(hi / 2), rand_vec(hi));
      end
      offer(MODE_AVAIL, PROC_W'($urandom), rand_vec(hi), rand_vec(255));
      repeat ($urandom_range(6, 20)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          offer(mode_t'($urandom_range(0, 3)), PROC_W'($urandom), rand_vec(255),
                rand_vec(255));
        end else if (pick < 3) begin
          offer(MODE_CHECK, PROC_W'($urandom), rand_vec(255), rand_vec(255));
        end else if (pick == 3) begin
          offer(MODE_REQ, PROC_W'($urandom_range(PROCS, 15)), rand_vec(hi), none);
        end else begin
          offer(MODE_REQ, PROC_W'($urandom_range(0, PROCS - 1)), rand_vec(hi / 3 + 1),
                rand_vec(255));
        end
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: stall phases of random length and density, plus one long
  // hold-off so that the unit backs up into its input.
  initial begin : drain_side
    int stall_pct;
    int span;
    bit held;
    out_if.ready <= 1'b0;
    held = 1'b0;
    forever begin
      span = $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0: begin
          stall_pct = 0;
        end
        1: begin
          stall_pct = 20;
        end
        2: begin
          stall_pct = 55;
        end
        default: begin
          stall_pct = 90;
        end
      endcase
      if (!held && words_sent >= 300) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_if.ready <= 1'b0;
        end
      end
      repeat (span) begin
        @(posedge clk);
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
